// ===== hdl/tfn_pkg.sv =====
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared widths and stage types for the triangle face normal pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package tfn_pkg;

  localparam int IDX_W   = 16;
  localparam int CRD_W   = 16;
  localparam int NRM_W   = 16;
  localparam int MAG_W   = 34;
  localparam int MN_W    = 30;
  localparam int SUM_W   = 62;
  localparam int ROOT_W  = 31;
  localparam int QUO_W   = 15;
  localparam int DREM_W  = 45;
  localparam int FRAC_W  = 14;
  localparam int LEN_W   = 6;

  typedef struct packed {
    logic                      deg;
    logic [2:0]                neg;
    logic [2:0][IDX_W-1:0]     idx;
  } tag_t;

  typedef struct packed {
    tag_t                      tag;
    logic [2:0][MN_W-1:0]      mn;
    logic [SUM_W-1:0]          rem;
    logic [ROOT_W-1:0]         root;
  } sq_t;

  typedef struct packed {
    tag_t                      tag;
    logic [ROOT_W-1:0]         den;
    logic [2:0][DREM_W-1:0]    rem;
    logic [2:0][QUO_W-1:0]     quo;
  } dv_t;

endpackage

`default_nettype wire

// ===== hdl/tfn_if.sv =====
// ----------------------------------------------------------------------------
// tfn_in_if / tfn_out_if
// Request and result channels of the triangle face normal block
// ----------------------------------------------------------------------------
`default_nettype none

interface tfn_in_if import tfn_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [CRD_W-1:0] corner_a_x;
  logic signed [CRD_W-1:0] corner_a_y;
  logic signed [CRD_W-1:0] corner_a_z;
  logic signed [CRD_W-1:0] corner_b_x;
  logic signed [CRD_W-1:0] corner_b_y;
  logic signed [CRD_W-1:0] corner_b_z;
  logic signed [CRD_W-1:0] corner_c_x;
  logic signed [CRD_W-1:0] corner_c_y;
  logic signed [CRD_W-1:0] corner_c_z;
  logic [IDX_W-1:0]        index_a;
  logic [IDX_W-1:0]        index_b;
  logic [IDX_W-1:0]        index_c;

  modport source (
    output valid, corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y,
           corner_b_z, corner_c_x, corner_c_y, corner_c_z, index_a, index_b, index_c,
    input  ready
  );
  modport sink (
    input  valid, corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y,
           corner_b_z, corner_c_x, corner_c_y, corner_c_z, index_a, index_b, index_c,
    output ready
  );
endinterface

interface tfn_out_if import tfn_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        corner_index;
  logic signed [NRM_W-1:0] normal_x;
  logic signed [NRM_W-1:0] normal_y;
  logic signed [NRM_W-1:0] normal_z;
  logic                    degenerate;
  logic                    last_corner;

  modport source (
    output valid, corner_index, normal_x, normal_y, normal_z, degenerate, last_corner,
    input  ready
  );
  modport sink (
    input  valid, corner_index, normal_x, normal_y, normal_z, degenerate, last_corner,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/triangle_face_normal.sv =====
// ----------------------------------------------------------------------------
// triangle_face_normal
// Unit face normal of one triangle (Q1.14), sent to each of its three corners
// ----------------------------------------------------------------------------
// channel   direction  payload
// in_ch     sink       three Q8.8 corners, three vertex indices
// out_ch    source     corner index, Q1.14 normal, degenerate, last corner
//
// 54 register stages from request to the result buffer: edges, products,
// cross, bit length, shift, squares, sum, 31 square root steps, one
// numerator stage, 15 divide steps. The buffer sends three results, one a
// cycle while out_ch.ready is high; a new triangle loads as the third goes.
// reset clears valid bits and cnt_r only; a stall freezes the whole pipe.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_face_normal import tfn_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  tfn_in_if.sink   in_ch,
  tfn_out_if.source out_ch
);

  logic adv;
  logic load;

  // edges
  logic                    v1_r;
  logic signed [CRD_W:0]   e1_r [3];
  logic signed [CRD_W:0]   e2_r [3];
  logic [2:0][IDX_W-1:0]   idx1_r;

  // products
  logic                    v2_r;
  logic signed [2*CRD_W+1:0] p_r [6];
  logic [2:0][IDX_W-1:0]   idx2_r;

  // cross magnitudes
  logic                    v3_r;
  logic [MAG_W-1:0]        m3_r [3];
  tag_t                    t3_r;
  logic signed [2*CRD_W+2:0] cr [3];

  // bit length
  logic                    v4_r;
  logic [MAG_W-1:0]        m4_r [3];
  logic [LEN_W-1:0]        len4_r;
  tag_t                    t4_r;
  logic [MAG_W-1:0]        mx;
  logic [LEN_W-1:0]        len;

  // shift
  logic                    v5_r;
  logic [2:0][MN_W-1:0]    mn5_r;
  tag_t                    t5_r;

  // squares
  logic                    v6_r;
  logic [2*MN_W-1:0]       sqr6_r [3];
  logic [2:0][MN_W-1:0]    mn6_r;
  tag_t                    t6_r;

  // square root and divide pipes
  sq_t                     sq_r  [0:ROOT_W];
  logic [0:ROOT_W]         sqv_r;
  dv_t                     dv_r  [0:QUO_W];
  logic [0:QUO_W]          dvv_r;

  // result buffer
  logic                    busy_r;
  logic [1:0]              cnt_r;
  logic [2:0][IDX_W-1:0]   hidx_r;
  logic [2:0][NRM_W-1:0]   nrm_r;
  logic                    deg_r;
  logic [2:0][NRM_W-1:0]   nrm_nxt;

  assign load = dvv_r[QUO_W] && (!busy_r || (out_ch.ready && cnt_r == 2'd2));
  assign adv  = !dvv_r[QUO_W] || load;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_ch.valid;
    if (adv) begin
      e1_r[0] <= {in_ch.corner_b_x[CRD_W-1], in_ch.corner_b_x}
               - {in_ch.corner_a_x[CRD_W-1], in_ch.corner_a_x};
      e1_r[1] <= {in_ch.corner_b_y[CRD_W-1], in_ch.corner_b_y}
               - {in_ch.corner_a_y[CRD_W-1], in_ch.corner_a_y};
      e1_r[2] <= {in_ch.corner_b_z[CRD_W-1], in_ch.corner_b_z}
               - {in_ch.corner_a_z[CRD_W-1], in_ch.corner_a_z};
      e2_r[0] <= {in_ch.corner_c_x[CRD_W-1], in_ch.corner_c_x}
               - {in_ch.corner_a_x[CRD_W-1], in_ch.corner_a_x};
      e2_r[1] <= {in_ch.corner_c_y[CRD_W-1], in_ch.corner_c_y}
               - {in_ch.corner_a_y[CRD_W-1], in_ch.corner_a_y};
      e2_r[2] <= {in_ch.corner_c_z[CRD_W-1], in_ch.corner_c_z}
               - {in_ch.corner_a_z[CRD_W-1], in_ch.corner_a_z};
      idx1_r  <= {in_ch.index_c, in_ch.index_b, in_ch.index_a};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
    if (adv) begin
      p_r[0] <= (2*CRD_W+2)'(e1_r[1]) * (2*CRD_W+2)'(e2_r[2]);
      p_r[1] <= (2*CRD_W+2)'(e1_r[2]) * (2*CRD_W+2)'(e2_r[1]);
      p_r[2] <= (2*CRD_W+2)'(e1_r[2]) * (2*CRD_W+2)'(e2_r[0]);
      p_r[3] <= (2*CRD_W+2)'(e1_r[0]) * (2*CRD_W+2)'(e2_r[2]);
      p_r[4] <= (2*CRD_W+2)'(e1_r[0]) * (2*CRD_W+2)'(e2_r[1]);
      p_r[5] <= (2*CRD_W+2)'(e1_r[1]) * (2*CRD_W+2)'(e2_r[0]);
      idx2_r <= idx1_r;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr[i] = {p_r[2*i][2*CRD_W+1], p_r[2*i]} - {p_r[2*i+1][2*CRD_W+1], p_r[2*i+1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        m3_r[i]       <= cr[i][2*CRD_W+2] ? MAG_W'(-cr[i]) : MAG_W'(cr[i]);
        t3_r.neg[i]   <= cr[i][2*CRD_W+2];
      end
      t3_r.deg <= (cr[0] == '0) && (cr[1] == '0) && (cr[2] == '0);
      t3_r.idx <= idx2_r;
    end
  end

  always_comb begin
    mx  = m3_r[0] | m3_r[1] | m3_r[2];
    len = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (mx[i]) len = LEN_W'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (adv) v4_r <= v3_r;
    if (adv) begin
      m4_r   <= m3_r;
      len4_r <= len;
      t4_r   <= t3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (adv) v5_r <= v4_r;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        mn5_r[i] <= MN_W'(({m4_r[i], {MN_W{1'b0}}}) >> len4_r);
      end
      t5_r <= t4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (adv) v6_r <= v5_r;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sqr6_r[i] <= (2*MN_W)'(mn5_r[i]) * (2*MN_W)'(mn5_r[i]);
      end
      mn6_r <= mn5_r;
      t6_r  <= t5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sqv_r[0] <= 1'b0;
    else if (adv) sqv_r[0] <= v6_r;
    if (adv) begin
      sq_r[0].tag  <= t6_r;
      sq_r[0].mn   <= mn6_r;
      sq_r[0].rem  <= SUM_W'(sqr6_r[0]) + SUM_W'(sqr6_r[1]) + SUM_W'(sqr6_r[2]);
      sq_r[0].root <= '0;
    end
  end

  // one root bit per stage, most significant first
  for (genvar j = 0; j < ROOT_W; j++) begin : g_sq
    localparam int K = ROOT_W - 1 - j;
    logic [63:0] trial;
    logic        take;
    sq_t         sq_nxt;
    assign trial = ({33'd0, sq_r[j].root} << (K + 1)) + (64'd1 << (2 * K));
    assign take  = {2'b00, sq_r[j].rem} >= trial;
    always_comb begin
      sq_nxt = sq_r[j];
      if (take) begin
        sq_nxt.rem  = sq_r[j].rem - trial[SUM_W-1:0];
        sq_nxt.root = sq_r[j].root | (ROOT_W'(1) << K);
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) sqv_r[j+1] <= 1'b0;
      else if (adv) sqv_r[j+1] <= sqv_r[j];
      if (adv) sq_r[j+1] <= sq_nxt;
    end
  end

  // rounded numerator
  always_ff @(posedge clk) begin
    if (!rst_n) dvv_r[0] <= 1'b0;
    else if (adv) dvv_r[0] <= sqv_r[ROOT_W];
    if (adv) begin
      dv_r[0].tag <= sq_r[ROOT_W].tag;
      dv_r[0].den <= sq_r[ROOT_W].root;
      dv_r[0].quo <= '0;
      for (int i = 0; i < 3; i++) begin
        dv_r[0].rem[i] <= {1'b0, sq_r[ROOT_W].mn[i], {FRAC_W{1'b0}}}
                        + DREM_W'(sq_r[ROOT_W].root >> 1);
      end
    end
  end

  // one quotient bit per stage on all three lanes
  for (genvar j = 0; j < QUO_W; j++) begin : g_dv
    localparam int K = QUO_W - 1 - j;
    logic [DREM_W-1:0] dsh;
    dv_t               dv_nxt;
    assign dsh = DREM_W'(dv_r[j].den) << K;
    always_comb begin
      dv_nxt = dv_r[j];
      for (int i = 0; i < 3; i++) begin
        if (dv_r[j].rem[i] >= dsh) begin
          dv_nxt.rem[i] = dv_r[j].rem[i] - dsh;
          dv_nxt.quo[i] = dv_r[j].quo[i] | (QUO_W'(1) << K);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dvv_r[j+1] <= 1'b0;
      else if (adv) dvv_r[j+1] <= dvv_r[j];
      if (adv) dv_r[j+1] <= dv_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_r[QUO_W].tag.deg) nrm_nxt[i] = '0;
      else if (dv_r[QUO_W].tag.neg[i]) nrm_nxt[i] = -{1'b0, dv_r[QUO_W].quo[i]};
      else nrm_nxt[i] = {1'b0, dv_r[QUO_W].quo[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else if (load) begin
      busy_r <= 1'b1;
      cnt_r  <= 2'd0;
    end else if (busy_r && out_ch.ready) begin
      if (cnt_r == 2'd2) busy_r <= 1'b0;
      cnt_r <= cnt_r + 2'd1;
    end
    if (load) begin
      hidx_r <= dv_r[QUO_W].tag.idx;
      nrm_r  <= nrm_nxt;
      deg_r  <= dv_r[QUO_W].tag.deg;
    end
  end

  assign out_ch.valid        = busy_r;
  assign out_ch.corner_index = hidx_r[cnt_r];
  assign out_ch.normal_x     = nrm_r[0];
  assign out_ch.normal_y     = nrm_r[1];
  assign out_ch.normal_z     = nrm_r[2];
  assign out_ch.degenerate   = deg_r;
  assign out_ch.last_corner  = (cnt_r == 2'd2);

endmodule

`default_nettype wire

// ===== tb/tb_triangle_face_normal.sv =====
// ----------------------------------------------------------------------------
// tb_triangle_face_normal
// Sends triangles through the face normal block under bursty requests and a
// stalling result side, predicts the three corner results of each accepted
// request and compares them in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_triangle_face_normal;
  import tfn_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 120;

  typedef struct {
    logic signed [CRD_W-1:0] crd [9];
    logic [IDX_W-1:0]        idx [3];
    bit                      drain_first;
  } tri_req_t;

  typedef struct {
    logic [IDX_W-1:0]        corner_index;
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
    logic                    degenerate;
    logic                    last_corner;
  } corner_normal_t;

  logic clk;
  logic rst_n;

  tfn_in_if  u_in ();
  tfn_out_if u_out ();

  triangle_face_normal i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (u_in.sink),
    .out_ch (u_out.source)
  );

  tri_req_t       pending_tris [$];
  corner_normal_t expected_normals [$];
  int             fail_count;
  int             results_seen;
  int             idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic void face_normals(input tri_req_t t);
    longint          a [3], b [3], c [3], e1 [3], e2 [3], cr [3];
    longint unsigned m [3];
    longint unsigned mx, s, r, q;
    int              len;
    logic [15:0]     nrm [3];
    bit              deg;
    corner_normal_t  res;
    for (int i = 0; i < 3; i++) begin
      a[i] = t.crd[i];
      b[i] = t.crd[3+i];
      c[i] = t.crd[6+i];
      e1[i] = b[i] - a[i];
      e2[i] = c[i] - a[i];
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    deg = (cr[0] == 0) && (cr[1] == 0) && (cr[2] == 0);
    for (int i = 0; i < 3; i++) nrm[i] = '0;
    if (!deg) begin
      mx = 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = (cr[i] < 0) ? longint'(-cr[i]) : longint'(cr[i]);
        if (m[i] > mx) mx = m[i];
      end
      len = 0;
      while (mx != 0) begin
        len++;
        mx >>= 1;
      end
      for (int i = 0; i < 3; i++) begin
        if (len < 30) m[i] = m[i] << (30 - len);
        else if (len > 30) m[i] = m[i] >> (len - 30);
        s += m[i] * m[i];
      end
      r = int_sqrt(s);
      if (r == 0) r = 1;
      for (int i = 0; i < 3; i++) begin
        q = ((m[i] << 14) + (r >> 1)) / r;
        if (q > 16384) q = 16384;
        nrm[i] = (cr[i] < 0) ? 16'(-q) : 16'(q);
      end
    end
    for (int k = 0; k < 3; k++) begin
      res.corner_index = t.idx[k];
      res.nx = nrm[0];
      res.ny = nrm[1];
      res.nz = nrm[2];
      res.degenerate = deg;
      res.last_corner = (k == 2);
      expected_normals.insert(expected_normals.size(), res);
    end
  endfunction

  // request side: bursts and gaps, optional drain before an item
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    logic next_valid;
    bit   accepted;
    next_valid = u_in.valid;
    accepted = 1'b0;
    if (!rst_n) begin
      next_valid = 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (u_in.valid && u_in.ready) begin
        face_normals(pending_tris.pop_front());
        accepted = 1'b1;
        next_valid = 1'b0;
      end
      if (!u_in.valid || accepted) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_tris.size() > 0 &&
                     !(pending_tris[0].drain_first && expected_normals.size() > 0)) begin
          next_valid = 1'b1;
          u_in.corner_a_x <= pending_tris[0].crd[0];
          u_in.corner_a_y <= pending_tris[0].crd[1];
          u_in.corner_a_z <= pending_tris[0].crd[2];
          u_in.corner_b_x <= pending_tris[0].crd[3];
          u_in.corner_b_y <= pending_tris[0].crd[4];
          u_in.corner_b_z <= pending_tris[0].crd[5];
          u_in.corner_c_x <= pending_tris[0].crd[6];
          u_in.corner_c_y <= pending_tris[0].crd[7];
          u_in.corner_c_z <= pending_tris[0].crd[8];
          u_in.index_a <= pending_tris[0].idx[0];
          u_in.index_b <= pending_tris[0].idx[1];
          u_in.index_c <= pending_tris[0].idx[2];
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
    u_in.valid <= next_valid;
  end

  // result side: own stall pattern plus one long hold-off
  int  stall_mode_left;
  bit  stall_mode;
  int  long_hold;
  bit  long_hold_done;

  always @(posedge clk) begin
    logic next_ready;
    corner_normal_t exp_r;
    if (!rst_n) begin
      next_ready = 1'b0;
      stall_mode_left = 0;
      stall_mode = 1'b0;
      long_hold = 0;
      long_hold_done = 1'b0;
    end else begin
      if (u_out.valid && u_out.ready) begin
        results_seen++;
        if (expected_normals.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual index %h", $time,
                   u_out.corner_index);
          fail_count++;
        end else begin
          exp_r = expected_normals.pop_front();
          if (u_out.corner_index !== exp_r.corner_index ||
              u_out.normal_x !== exp_r.nx || u_out.normal_y !== exp_r.ny ||
              u_out.normal_z !== exp_r.nz || u_out.degenerate !== exp_r.degenerate ||
              u_out.last_corner !== exp_r.last_corner) begin
            $display("%0t: mismatch expected idx %h n %0d %0d %0d deg %b last %b",
                     $time, exp_r.corner_index, exp_r.nx, exp_r.ny, exp_r.nz,
                     exp_r.degenerate, exp_r.last_corner);
            $display("%0t:          actual   idx %h n %0d %0d %0d deg %b last %b",
                     $time, u_out.corner_index, u_out.normal_x, u_out.normal_y,
                     u_out.normal_z, u_out.degenerate, u_out.last_corner);
            fail_count++;
          end
        end
      end
      if (!long_hold_done && results_seen >= 90) begin
        long_hold = 400;
        long_hold_done = 1'b1;
      end
      if (stall_mode_left == 0) begin
        stall_mode_left = $urandom_range(20, 80);
        stall_mode = 1'($urandom_range(0, 1));
      end else begin
        stall_mode_left--;
      end
      if (long_hold > 0) begin
        long_hold--;
        next_ready = 1'b0;
      end else if (stall_mode) begin
        next_ready = ($urandom_range(0, 2) != 0);
      end else begin
        next_ready = 1'b1;
      end
    end
    u_out.ready <= next_ready;
  end

  always @(posedge clk) begin
    if (!rst_n || (u_in.valid && u_in.ready) || (u_out.valid && u_out.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic tri_req_t make_tri(input int ax, ay, az, bx, by, bz, cx, cy, cz,
                                        input int ia, ib, ic);
    tri_req_t t;
    t.crd[0] = 16'(ax); t.crd[1] = 16'(ay); t.crd[2] = 16'(az);
    t.crd[3] = 16'(bx); t.crd[4] = 16'(by); t.crd[5] = 16'(bz);
    t.crd[6] = 16'(cx); t.crd[7] = 16'(cy); t.crd[8] = 16'(cz);
    t.idx[0] = 16'(ia); t.idx[1] = 16'(ib); t.idx[2] = 16'(ic);
    t.drain_first = 1'b0;
    return t;
  endfunction

  function automatic void add_tri(input tri_req_t t);
    pending_tris.insert(pending_tris.size(), t);
  endfunction

  initial begin
    tri_req_t t;
    int       sc;
    fail_count = 0;
    results_seen = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    u_in.valid = 1'b0;
    u_out.ready = 1'b0;
    u_in.corner_a_x = '0; u_in.corner_a_y = '0; u_in.corner_a_z = '0;
    u_in.corner_b_x = '0; u_in.corner_b_y = '0; u_in.corner_b_z = '0;
    u_in.corner_c_x = '0; u_in.corner_c_y = '0; u_in.corner_c_z = '0;
    u_in.index_a = '0; u_in.index_b = '0; u_in.index_c = '0;

    // axis aligned, extremes, degenerate and collinear cases
    add_tri(make_tri(0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 1, 2));
    add_tri(make_tri(0, 0, 0, 0, 256, 0, 0, 0, 256, 65535, 0, 65535));
    add_tri(make_tri(0, 0, 0, 0, 0, 256, 256, 0, 0, 3, 4, 5));
    add_tri(make_tri(5, 5, 5, 5, 5, 5, 5, 5, 5, 10, 11, 12));
    add_tri(make_tri(0, 0, 0, 2, 4, 6, 1, 2, 3, 13, 14, 15));
    add_tri(make_tri(-32768, -32768, -32768, 32767, -32768, -32768,
                     -32768, 32767, -32768, 100, 200, 300));
    add_tri(make_tri(32767, 32767, 32767, -32768, 32767, 32767,
                     32767, -32768, 32767, 65535, 65535, 65535));
    add_tri(make_tri(-32768, 32767, -32768, 32767, -32768, 32767,
                     32767, 32767, -32768, 1, 2, 3));
    add_tri(make_tri(-32768, -32768, -32768, -32768, -32768, -32768,
                     32767, 32767, 32767, 7, 8, 9));
    add_tri(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 0));
    add_tri(make_tri(0, 0, 0, 1, 1, 0, 1, 0, 1, 21, 22, 23));
    add_tri(make_tri(0, 0, 0, 32767, 1, 0, 1, 32767, 0, 31, 32, 33));
    add_tri(make_tri(100, -50, 7, -3, 900, 12, 40, 40, -2000, 41, 42, 43));
    add_tri(make_tri(0, 0, 0, -1, -1, -1, 1, 1, 1, 51, 52, 53));
    t = make_tri(0, 0, 0, 0, 256, 0, 256, 0, 0, 61, 62, 63);
    t.drain_first = 1'b1;
    add_tri(t);

    for (int n = 0; n < 95; n++) begin
      sc = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++) begin
        if (sc < 5) t.crd[i] = 16'($urandom());
        else if (sc < 8) t.crd[i] = 16'($urandom_range(0, 127)) - 16'd64;
        else t.crd[i] = (i < 3) ? 16'($urandom()) : t.crd[i % 3];
      end
      if (sc == 9) t.crd[3 + $urandom_range(0, 5)] = 16'($urandom());
      for (int k = 0; k < 3; k++) t.idx[k] = 16'($urandom());
      t.drain_first = (n == 55);
      add_tri(t);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_tris.size() == 0);
    wait (expected_normals.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_normals.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
